// ===== rtl/bwhd_pkg.sv =====
package bwhd_pkg;

   localparam int XW  = 20;  // Q15.4 coordinate
   localparam int ZW  = 16;  // Q4.12 zoom
   localparam int LOW = 21;  // 30 * zoom
   localparam int HIW = 24;  // 160 * zoom
   localparam int CW  = 31;  // Q.12 offset from query point
   localparam int UW  = 7;   // sample index
   localparam int U2W = 13;  // index squared
   localparam int WW  = 19;  // Bernstein weight, up to SAMPLES^3
   localparam int SW  = 50;  // weighted sum
   localparam int NW  = 48;  // dividend magnitude
   localparam int QW  = 26;  // per-axis offset magnitude, Q.8
   localparam int VW  = 40;  // squared distance, Q.8, clamped
   localparam int RW  = 20;  // distance, Q16.4

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PW    = 1;

   localparam logic REG_ZOOM = 1'b0;
   localparam logic [ZW-1:0] ZOOM_RESET = 16'd4096;

   typedef struct packed {
      logic signed [CW-1:0] a0;
      logic signed [CW-1:0] a1;
      logic signed [CW-1:0] a2;
      logic signed [CW-1:0] a3;
      logic signed [CW-1:0] b0;
      logic signed [CW-1:0] b2;
   } wire_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

// ===== rtl/bwhd_front.sv =====
module bwhd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [bwhd_pkg::LOW-1:0]           lo_limit,
   input  logic [bwhd_pkg::HIW-1:0]           hi_limit,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bwhd_pkg::XW-1:0]     req_start_x,
   input  logic signed [bwhd_pkg::XW-1:0]     req_start_y,
   input  logic signed [bwhd_pkg::XW-1:0]     req_end_x,
   input  logic signed [bwhd_pkg::XW-1:0]     req_end_y,
   input  logic signed [bwhd_pkg::XW-1:0]     req_query_x,
   input  logic signed [bwhd_pkg::XW-1:0]     req_query_y,
   input  logic                               q_full,
   output logic                               q_push,
   output bwhd_pkg::wire_type                 q_entry
);

   localparam int XW = bwhd_pkg::XW;
   localparam int CW = bwhd_pkg::CW;

   logic                 valid_ff;
   logic signed [XW-1:0] sx_ff, sy_ff, ex_ff, ey_ff, qx_ff, qy_ff;

   logic signed [XW:0]   gx, dsx, dsy, dex, dey;
   logic [XW:0]          gap;
   logic [XW+7:0]        half;
   logic [XW+7:0]        strength;
   logic signed [CW-1:0] a0, a3, sv;

   assign req_ready = !valid_ff || !q_full;
   assign q_push    = valid_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         sx_ff <= req_start_x;
         sy_ff <= req_start_y;
         ex_ff <= req_end_x;
         ey_ff <= req_end_y;
         qx_ff <= req_query_x;
         qy_ff <= req_query_y;
      end
   end

   // tangent strength: half the horizontal gap in Q.12, clamped to the zoom limits
   always_comb begin
      gx   = (XW+1)'(ex_ff) - (XW+1)'(sx_ff);
      gap  = gx[XW] ? (XW+1)'(-gx) : (XW+1)'(gx);
      half = {gap, 7'b0};
      if (half < (XW+8)'(lo_limit)) begin
         strength = (XW+8)'(lo_limit);
      end else if (half > (XW+8)'(hi_limit)) begin
         strength = (XW+8)'(hi_limit);
      end else begin
         strength = half;
      end
   end

   assign dsx = (XW+1)'(sx_ff) - (XW+1)'(qx_ff);
   assign dsy = (XW+1)'(sy_ff) - (XW+1)'(qy_ff);
   assign dex = (XW+1)'(ex_ff) - (XW+1)'(qx_ff);
   assign dey = (XW+1)'(ey_ff) - (XW+1)'(qy_ff);

   assign a0 = CW'(signed'({dsx, 8'b0}));
   assign a3 = CW'(signed'({dex, 8'b0}));
   assign sv = CW'(signed'({1'b0, strength}));

   always_comb begin
      q_entry.a0 = a0;
      q_entry.a1 = a0 + sv;
      q_entry.a2 = a3 - sv;
      q_entry.a3 = a3;
      q_entry.b0 = CW'(signed'({dsy, 8'b0}));
      q_entry.b2 = CW'(signed'({dey, 8'b0}));
   end

endmodule

// ===== rtl/bwhd_fifo.sv =====
module bwhd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bwhd_pkg::wire_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output bwhd_pkg::wire_type head
);

   localparam int DEPTH = bwhd_pkg::FIFO_DEPTH;
   localparam int PW    = bwhd_pkg::FIFO_PW;

   bwhd_pkg::wire_type mem_ff [DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]        count_ff, count_in;

   assign full  = count_ff == (PW+1)'(DEPTH);
   assign valid = count_ff != '0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/bwhd_div.sv =====
// Two dividers by a constant in lockstep, done as a reciprocal multiply: the quotient is
// bits K and up of num * ceil(2^K / DIVISOR), exact for any numerator below 2^NW.
// Partial products are registered in the first stage and summed in the second.
module bwhd_div #(
   parameter int DIVISOR = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  bwhd_pkg::tag_type          in_tag,
   input  logic [bwhd_pkg::NW-1:0]    num_x,
   input  logic [bwhd_pkg::NW-1:0]    num_y,
   output bwhd_pkg::tag_type          out_tag,
   output logic [bwhd_pkg::QW-1:0]    quo_x,
   output logic [bwhd_pkg::QW-1:0]    quo_y
);

   localparam int NW  = bwhd_pkg::NW;
   localparam int QW  = bwhd_pkg::QW;
   localparam int MW  = NW + 1;
   localparam int NLO = NW / 2;
   localparam int MLO = MW - MW / 2;
   localparam int MHI = MW - MLO;
   localparam int PPW = (NW - NLO) + MLO;
   localparam int PW  = NW + MW;
   localparam int K   = NW + $clog2(DIVISOR);
   localparam logic [PW-1:0] MAGIC =
      ((PW'(1) << K) + PW'(DIVISOR) - PW'(1)) / PW'(DIVISOR);
   localparam logic [MHI-1:0] M_HI = MAGIC[MW-1:MLO];
   localparam logic [MLO-1:0] M_LO = MAGIC[MLO-1:0];

   logic [NW-1:0]     num    [2];
   logic [PPW-1:0]    hh_ff  [2];
   logic [PPW-1:0]    hl_ff  [2];
   logic [PPW-1:0]    lh_ff  [2];
   logic [PPW-1:0]    ll_ff  [2];
   logic [QW-1:0]     quo_ff [2];
   bwhd_pkg::tag_type tag1_ff, tag2_ff;

   assign num[0] = num_x;
   assign num[1] = num_y;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [PW-1:0] prod;

      assign prod = (PW'(hh_ff[a]) << (NLO + MLO)) + (PW'(hl_ff[a]) << NLO)
                  + (PW'(lh_ff[a]) << MLO) + PW'(ll_ff[a]);

      always_ff @(posedge clock) begin
         if (en) begin
            hh_ff[a]  <= PPW'(num[a][NW-1:NLO]) * PPW'(M_HI);
            hl_ff[a]  <= PPW'(num[a][NW-1:NLO]) * PPW'(M_LO);
            lh_ff[a]  <= PPW'(num[a][NLO-1:0]) * PPW'(M_HI);
            ll_ff[a]  <= PPW'(num[a][NLO-1:0]) * PPW'(M_LO);
            quo_ff[a] <= prod[K +: QW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (en) begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_tag = tag2_ff;
   assign quo_x   = quo_ff[0];
   assign quo_y   = quo_ff[1];

endmodule

// ===== rtl/bwhd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
module bwhd_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [bwhd_pkg::VW-1:0] radicand,
   output logic                    out_valid,
   output logic [bwhd_pkg::RW-1:0] root
);

   localparam int VW = bwhd_pkg::VW;
   localparam int RW = bwhd_pkg::RW;

   logic [VW:0]   rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic          vld_ff  [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      localparam int B = RW - 1 - j;
      logic [VW:0]   rem_prev, trial;
      logic [RW-1:0] root_prev;
      logic          v_prev, take;

      if (j == 0) begin : g_head
         assign rem_prev  = (VW+1)'(radicand);
         assign root_prev = '0;
         assign v_prev    = in_valid;
      end else begin : g_body
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign v_prev    = vld_ff[j-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = ((VW+1)'(root_prev) << (B+1)) + ((VW+1)'(1) << (2*B));
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_prev;
         end
         if (en) begin
            rem_ff[j]  <= take ? rem_prev - trial : rem_prev;
            root_ff[j] <= root_prev | (RW'(take) << B);
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign root      = root_ff[RW-1];

endmodule

// ===== rtl/bwhd_back.sv =====
module bwhd_back #(
   parameter int SAMPLES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    q_valid,
   input  bwhd_pkg::wire_type      q_entry,
   output logic                    q_pop,
   output logic                    res_valid,
   output logic [bwhd_pkg::RW-1:0] res_dist
);

   localparam int UW  = bwhd_pkg::UW;
   localparam int U2W = bwhd_pkg::U2W;
   localparam int WW  = bwhd_pkg::WW;
   localparam int SW  = bwhd_pkg::SW;
   localparam int NW  = bwhd_pkg::NW;
   localparam int QW  = bwhd_pkg::QW;
   localparam int VW  = bwhd_pkg::VW;
   localparam int IW  = $clog2(SAMPLES + 1);
   localparam int DIVISOR = 16 * SAMPLES * SAMPLES * SAMPLES;
   localparam logic signed [SW-1:0] HALF_S = SW'(DIVISOR / 2);
   localparam logic signed [SW-1:0] DM1_S  = SW'(DIVISOR - 1);

   // sample issue
   logic [IW-1:0] idx_ff, idx_in;
   logic          at_end;
   logic [UW-1:0] u0, i0;

   assign at_end = idx_ff == IW'(SAMPLES);
   assign q_pop  = adv && q_valid && at_end;
   assign u0     = UW'(SAMPLES) - UW'(idx_ff);
   assign i0     = UW'(idx_ff);

   always_comb begin
      idx_in = idx_ff;
      if (adv && q_valid) begin
         idx_in = at_end ? '0 : idx_ff + 1'b1;
      end
   end

   // weight stages
   bwhd_pkg::tag_type  t1_ff, t2_ff, tp_ff, ts_ff, tm_ff, tq_ff, tv_ff, td;
   bwhd_pkg::wire_type e1_ff, e2_ff;
   logic [UW-1:0]      u1_ff, i1_ff;
   logic [U2W-1:0]     uu1_ff, ii1_ff;
   logic [WW-1:0]      w0_ff, w1_ff, w2_ff, w3_ff;
   logic [WW-1:0]      m1, m2;

   assign m1 = WW'(uu1_ff) * WW'(i1_ff);
   assign m2 = WW'(ii1_ff) * WW'(u1_ff);

   // products, sums, magnitudes
   logic signed [SW-1:0] px0_ff, px1_ff, px2_ff, px3_ff;
   logic signed [SW-1:0] py0_ff, py1_ff, py2_ff, py3_ff;
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic signed [SW-1:0] wx0, wx1, wx2, wx3;
   logic signed [SW-1:0] ax_mag, ay_mag;
   logic [NW-1:0]        nx_ff, ny_ff;
   logic [QW-1:0]        qx, qy;
   logic [2*QW-1:0]      sqx_ff, sqy_ff;
   logic [2*QW:0]        tot;
   logic [VW-1:0]        vv_ff, vv_in, best_ff, best_in;
   logic                 fin_valid_ff;
   logic [VW-1:0]        fin_ff;

   assign wx0 = SW'(signed'({1'b0, w0_ff}));
   assign wx1 = SW'(signed'({1'b0, w1_ff}));
   assign wx2 = SW'(signed'({1'b0, w2_ff}));
   assign wx3 = SW'(signed'({1'b0, w3_ff}));

   // floor((s + D/2) / D) taken as a magnitude: negative side rounds up
   assign ax_mag = sx_ff[SW-1] ? DM1_S - sx_ff : sx_ff;
   assign ay_mag = sy_ff[SW-1] ? DM1_S - sy_ff : sy_ff;

   assign tot = (2*QW+1)'(sqx_ff) + (2*QW+1)'(sqy_ff);

   always_comb begin
      if (tot[2*QW:VW+8] != '0) begin
         vv_in = '1;
      end else begin
         vv_in = tot[VW+7:8];
      end
   end

   assign best_in = (tv_ff.first || vv_ff < best_ff) ? vv_ff : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         tp_ff        <= '0;
         ts_ff        <= '0;
         tm_ff        <= '0;
         tq_ff        <= '0;
         tv_ff        <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (adv) begin
            t1_ff.valid  <= q_valid;
            t1_ff.first  <= idx_ff == '0;
            t1_ff.last   <= at_end;
            t2_ff        <= t1_ff;
            tp_ff        <= t2_ff;
            ts_ff        <= tp_ff;
            tm_ff        <= ts_ff;
            tq_ff        <= td;
            tv_ff        <= tq_ff;
            fin_valid_ff <= tv_ff.valid && tv_ff.last;
         end
      end
      if (adv) begin
         e1_ff  <= q_entry;
         u1_ff  <= u0;
         i1_ff  <= i0;
         uu1_ff <= U2W'(u0) * U2W'(u0);
         ii1_ff <= U2W'(i0) * U2W'(i0);

         e2_ff <= e1_ff;
         w0_ff <= WW'(uu1_ff) * WW'(u1_ff);
         w1_ff <= m1 + (m1 << 1);
         w2_ff <= m2 + (m2 << 1);
         w3_ff <= WW'(ii1_ff) * WW'(i1_ff);

         px0_ff <= SW'(e2_ff.a0) * wx0;
         px1_ff <= SW'(e2_ff.a1) * wx1;
         px2_ff <= SW'(e2_ff.a2) * wx2;
         px3_ff <= SW'(e2_ff.a3) * wx3;
         py0_ff <= SW'(e2_ff.b0) * wx0;
         py1_ff <= SW'(e2_ff.b0) * wx1;
         py2_ff <= SW'(e2_ff.b2) * wx2;
         py3_ff <= SW'(e2_ff.b2) * wx3;

         sx_ff <= px0_ff + px1_ff + px2_ff + px3_ff + HALF_S;
         sy_ff <= py0_ff + py1_ff + py2_ff + py3_ff + HALF_S;

         nx_ff <= NW'(ax_mag);
         ny_ff <= NW'(ay_mag);

         sqx_ff <= (2*QW)'(qx) * (2*QW)'(qx);
         sqy_ff <= (2*QW)'(qy) * (2*QW)'(qy);

         vv_ff <= vv_in;

         if (tv_ff.valid) begin
            best_ff <= best_in;
         end
         fin_ff <= best_in;
      end
   end

   bwhd_div #(
      .DIVISOR(DIVISOR)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_tag  (tm_ff),
      .num_x   (nx_ff),
      .num_y   (ny_ff),
      .out_tag (td),
      .quo_x   (qx),
      .quo_y   (qy)
   );

   bwhd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fin_valid_ff),
      .radicand  (fin_ff),
      .out_valid (res_valid),
      .root      (res_dist)
   );

`ifndef NO_ASSERTIONS
   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(SAMPLES))
      else $error("sample index past last sample");

   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && at_end)
      else $error("queue popped without a finished wire");

   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(fin_ff) && $stable(best_ff) && $stable(idx_ff))
      else $error("back pipeline moved while stalled");

   a_first_after_last : assert property (@(posedge clock) disable iff (reset)
      adv && t1_ff.valid && t1_ff.last |=> !(t1_ff.valid && !t1_ff.first) || !$past(adv))
      else $error("new wire did not restart at first sample");
`endif

endmodule

// ===== rtl/bezier_wire_hit_distance_unit.sv =====
// Cubic Bezier wire hit distance. Each transfer on req_ brings start pin, end pin and query
// point (signed Q15.4); one transfer on rsp_ returns the smallest distance (Q16.4,
// saturating) from the query point to SAMPLES+1 evenly spaced points on a horizontal Bezier
// wire whose tangent strength is half the horizontal gap, clamped to 30..160 times zoom.
// The sampler issues one curve point per cycle while a wire waits and the back pipeline is
// not held; a small queue after the input stage holds up to two waiting wires. On the way
// to rsp_valid a result passes weights, products, a two-stage reciprocal divider and a
// 20-stage square root. zoom (Q4.12, reset 1.0) sits at address 0 and is to be written
// only while the block is idle.
module bezier_wire_hit_distance_unit #(
   parameter int SAMPLES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [bwhd_pkg::XW-1:0] req_start_x,
   input  logic signed [bwhd_pkg::XW-1:0] req_start_y,
   input  logic signed [bwhd_pkg::XW-1:0] req_end_x,
   input  logic signed [bwhd_pkg::XW-1:0] req_end_y,
   input  logic signed [bwhd_pkg::XW-1:0] req_query_x,
   input  logic signed [bwhd_pkg::XW-1:0] req_query_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bwhd_pkg::RW-1:0]        rsp_distance,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int ZW  = bwhd_pkg::ZW;
   localparam int LOW = bwhd_pkg::LOW;
   localparam int HIW = bwhd_pkg::HIW;
   localparam int RW  = bwhd_pkg::RW;

   logic [ZW-1:0]  zoom_ff, zoom_in;
   logic [LOW-1:0] lo_ff;
   logic [HIW-1:0] hi_ff;
   logic           wr_zoom;

   assign csr_pready = 1'b1;
   assign wr_zoom    = csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == bwhd_pkg::REG_ZOOM;
   assign zoom_in    = csr_pwdata[ZW-1:0];
   assign csr_prdata = (csr_paddr[2] == bwhd_pkg::REG_ZOOM) ? 32'(zoom_ff) : '0;

   // limits kept pre-scaled so the front end only compares
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= bwhd_pkg::ZOOM_RESET;
         lo_ff   <= LOW'(30 * bwhd_pkg::ZOOM_RESET);
         hi_ff   <= HIW'(160 * bwhd_pkg::ZOOM_RESET);
      end else if (wr_zoom) begin
         zoom_ff <= zoom_in;
         lo_ff   <= (LOW'(zoom_in) << 5) - (LOW'(zoom_in) << 1);
         hi_ff   <= (HIW'(zoom_in) << 7) + (HIW'(zoom_in) << 5);
      end
   end

   logic               q_push, q_full, q_pop, q_valid;
   bwhd_pkg::wire_type push_entry, head;
   logic               adv, res_valid;
   logic [RW-1:0]      res_dist;
   logic               out_valid_ff;
   logic [RW-1:0]      out_dist_ff;

   bwhd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .lo_limit    (lo_ff),
      .hi_limit    (hi_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_query_x (req_query_x),
      .req_query_y (req_query_y),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   bwhd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (head)
   );

   // the whole back pipeline holds while a finished result waits
   assign adv = !out_valid_ff || rsp_ready;

   bwhd_back #(
      .SAMPLES(SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .q_valid   (q_valid),
      .q_entry   (head),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_dist  (res_dist)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= res_valid;
      end
      if (adv) begin
         out_dist_ff <= res_dist;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_distance = out_dist_ff;

endmodule
